// ===== rtl/urbr_pkg.sv =====
// ----------------------------------------------------------------------------
// urbr_pkg: shared types and constants for the UART register block
// Beat payloads, opcodes, register offsets, receive queue records and the
// command and status bundles passed between the core and the receive queue.
// ----------------------------------------------------------------------------
`default_nettype none

package urbr_pkg;

	// Item opcodes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Responder modes
	localparam logic [1:0] MODE_NONE      = 2'd0;
	localparam logic [1:0] MODE_HANDSHAKE = 2'd1;
	localparam logic [1:0] MODE_STREAM    = 2'd2;

	// Configuration register indexes
	localparam logic [0:0] CFG_RESPONDER_MODE = 1'b0;
	localparam logic [0:0] CFG_REFILL_PERIOD  = 1'b1;

	// Register byte offsets (two-byte stride)
	localparam logic [11:0] ADDR_RBR = 12'h000;
	localparam logic [11:0] ADDR_IER = 12'h002;
	localparam logic [11:0] ADDR_IIR = 12'h004;
	localparam logic [11:0] ADDR_LCR = 12'h006;
	localparam logic [11:0] ADDR_MCR = 12'h008;
	localparam logic [11:0] ADDR_LSR = 12'h00A;
	localparam logic [11:0] ADDR_MSR = 12'h00C;
	localparam logic [11:0] ADDR_SCR = 12'h00E;

	localparam int unsigned LCR_DLAB_BIT = 7;
	localparam logic [15:0] IIR_VALUE    = 16'h0001;
	localparam logic [15:0] LSR_BASE     = 16'h0060;
	localparam logic [15:0] PERIOD_RESET = 16'd240;

	// Handshake byte patterns and status codes
	localparam logic [7:0] HS_RESET_HI  = 8'h20;
	localparam logic [7:0] HS_RESET_LO  = 8'h00;
	localparam logic [7:0] HS_PROBE     = 8'h1f;
	localparam logic [7:0] HS_CALIB_HI  = 8'h14;
	localparam logic [7:0] HS_CALIB_LO  = 8'h1a;
	localparam logic [7:0] HS_DONE_HI   = 8'h11;
	localparam logic [7:0] HS_DONE_LO   = 8'h03;
	localparam logic [7:0] STAT_OK      = 8'h00;
	localparam logic [7:0] STAT_READY   = 8'h01;
	localparam logic [7:0] STAT_BUSY    = 8'h80;
	localparam logic [2:0] CALIB_MAX    = 3'd5;
	localparam logic [2:0] CALIB_LIMIT  = 3'd4;

	// Status streamer bytes
	localparam logic [7:0] STREAM_B0 = 8'h43;
	localparam logic [7:0] STREAM_B1 = 8'h30;
	localparam logic [7:0] STREAM_B2 = 8'h31;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] reg_addr;
		logic [15:0] write_data;
		logic [15:0] tick_cycles;
	} in_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_pulse;
	} out_t;

	// One queue record stands for the bytes of one push
	typedef enum logic [1:0] {
		REC_PAIR,
		REC_SINGLE,
		REC_TRIPLE
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t   kind;
		logic [7:0]  status;
	} rec_t;

	typedef struct packed {
		logic       clear;
		logic       pop;
		logic       push_hs;
		logic       push_stream;
		logic [7:0] status;
	} rxq_cmd_t;

	typedef struct packed {
		logic       empty;
		logic [7:0] head_byte;
	} rxq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/urbr_ram.sv =====
// ----------------------------------------------------------------------------
// urbr_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// contents from before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module urbr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/urbr_rxq.sv =====
// ----------------------------------------------------------------------------
// urbr_rxq: receive queue
// Byte queue held as records in a RAM, one record per push, with a byte
// offset into the head record so that pops drain one byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module urbr_rxq #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire urbr_pkg::rxq_cmd_t   cmd,
	output urbr_pkg::rxq_stat_t       stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RW = $bits(urbr_pkg::rec_t);

	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [1:0]    off_q, off_d;
	logic [1:0]    head_len;
	logic          we;
	urbr_pkg::rec_t wrec;
	urbr_pkg::rec_t head_rec;
	urbr_pkg::rec_t byp_rec_q;
	logic          byp_q;
	logic [RW-1:0] ram_rdata;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	urbr_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(wr_ptr_q),
		.wdata(wrec),
		.raddr(rd_ptr_d),
		.rdata(ram_rdata)
	);

	// The RAM is read at the next head address every cycle; a record written
	// to that address in the same cycle is taken from the bypass register.
	assign head_rec = byp_q ? byp_rec_q : urbr_pkg::rec_t'(ram_rdata);

	always_comb begin
		case (head_rec.kind)
			urbr_pkg::REC_PAIR:   head_len = 2'd2;
			urbr_pkg::REC_TRIPLE: head_len = 2'd3;
			default:              head_len = 2'd1;
		endcase
	end

	always_comb begin
		stat.empty = (cnt_q == '0);
		case (head_rec.kind)
			urbr_pkg::REC_PAIR: begin
				stat.head_byte = (off_q == 2'd0) ? head_rec.status : urbr_pkg::STAT_OK;
			end
			urbr_pkg::REC_TRIPLE: begin
				case (off_q)
					2'd0:    stat.head_byte = urbr_pkg::STREAM_B0;
					2'd1:    stat.head_byte = urbr_pkg::STREAM_B1;
					default: stat.head_byte = urbr_pkg::STREAM_B2;
				endcase
			end
			default: stat.head_byte = head_rec.status;
		endcase
	end

	always_comb begin
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		cnt_d       = cnt_q;
		off_d       = off_q;
		we          = 1'b0;
		wrec.kind   = urbr_pkg::REC_PAIR;
		wrec.status = cmd.status;
		if (cmd.clear) begin
			rd_ptr_d = wr_ptr_q;
			cnt_d    = '0;
			off_d    = 2'd0;
		end else if (cmd.pop && (cnt_q != '0)) begin
			cnt_d = cnt_q - 1'b1;
			if ((off_q + 2'd1) == head_len) begin
				off_d    = 2'd0;
				rd_ptr_d = ptr_inc(rd_ptr_q);
			end else begin
				off_d = off_q + 2'd1;
			end
		end else if (cmd.push_hs && (cnt_q < CW'(DEPTH))) begin
			we       = 1'b1;
			wr_ptr_d = ptr_inc(wr_ptr_q);
			if (cnt_q <= CW'(DEPTH - 2)) begin
				cnt_d = cnt_q + CW'(2);
			end else begin
				// Only the status byte fits; the trailing zero is dropped.
				wrec.kind = urbr_pkg::REC_SINGLE;
				cnt_d     = cnt_q + CW'(1);
			end
		end else if (cmd.push_stream && (cnt_q == '0)) begin
			we        = 1'b1;
			wr_ptr_d  = ptr_inc(wr_ptr_q);
			wrec.kind = urbr_pkg::REC_TRIPLE;
			cnt_d     = CW'(3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			off_q    <= 2'd0;
			byp_q    <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			cnt_q    <= cnt_d;
			off_q    <= off_d;
			byp_q    <= we && (wr_ptr_q == rd_ptr_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_rec_q <= wrec;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("receive queue byte count above its depth");

	a_off_in_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (off_q < head_len))
		else $error("receive queue offset outside the head record");
`endif

endmodule

`default_nettype wire

// ===== rtl/urbr_core.sv =====
// ----------------------------------------------------------------------------
// urbr_core: register file and board responders
// Decodes one item against the current register state, forms its result and
// updates the registers, responder state and receive queue when it commits.
// ----------------------------------------------------------------------------
`default_nettype none

module urbr_core #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire urbr_pkg::in_t  item,
	input  wire logic           cfg_wr_en,
	input  wire logic [0:0]     cfg_index,
	input  wire logic [15:0]    cfg_wdata,
	output urbr_pkg::out_t      res
);

	logic [1:0]  mode_q;
	logic [15:0] period_q;
	logic [15:0] ier_q, ier_d;
	logic [15:0] lcr_q, lcr_d;
	logic [15:0] mcr_q, mcr_d;
	logic [15:0] scr_q, scr_d;
	logic [15:0] dll_q, dll_d;
	logic [15:0] dlh_q, dlh_d;
	logic        parity_q, parity_d;
	logic [7:0]  prev_q, prev_d;
	logic [2:0]  calib_q, calib_d;
	logic        done_q, done_d;
	logic [16:0] acc_q, acc_d;
	logic [16:0] acc_sum;
	logic        dlab;
	logic [7:0]  cur;
	urbr_pkg::rxq_cmd_t  cmd, cmd_g;
	urbr_pkg::rxq_stat_t qstat;

	assign dlab    = lcr_q[urbr_pkg::LCR_DLAB_BIT];
	assign cur     = item.write_data[7:0];
	assign acc_sum = acc_q + {1'b0, item.tick_cycles};
	assign cmd_g   = step ? cmd : '0;

	urbr_rxq #(
		.DEPTH(DEPTH)
	) u_rxq (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_g),
		.stat  (qstat)
	);

	always_comb begin
		res      = '0;
		cmd      = '0;
		ier_d    = ier_q;
		lcr_d    = lcr_q;
		mcr_d    = mcr_q;
		scr_d    = scr_q;
		dll_d    = dll_q;
		dlh_d    = dlh_q;
		parity_d = parity_q;
		prev_d   = prev_q;
		calib_d  = calib_q;
		done_d   = done_q;
		acc_d    = acc_q;
		case (item.opcode)
			urbr_pkg::OP_READ: begin
				case (item.reg_addr)
					urbr_pkg::ADDR_RBR: begin
						if (dlab) begin
							res.read_data = dll_q;
						end else begin
							cmd.pop       = 1'b1;
							res.read_data = qstat.empty ? 16'h0000 : {8'h00, qstat.head_byte};
						end
					end
					urbr_pkg::ADDR_IER: res.read_data = dlab ? dlh_q : ier_q;
					urbr_pkg::ADDR_IIR: res.read_data = urbr_pkg::IIR_VALUE;
					urbr_pkg::ADDR_LCR: res.read_data = lcr_q;
					urbr_pkg::ADDR_MCR: res.read_data = mcr_q;
					urbr_pkg::ADDR_LSR: res.read_data = urbr_pkg::LSR_BASE | {15'h0000, !qstat.empty};
					urbr_pkg::ADDR_SCR: res.read_data = scr_q;
					default:            res.read_data = 16'h0000;
				endcase
			end
			urbr_pkg::OP_WRITE: begin
				case (item.reg_addr)
					urbr_pkg::ADDR_RBR: begin
						if (dlab) begin
							dll_d = item.write_data;
						end else if (mode_q == urbr_pkg::MODE_HANDSHAKE) begin
							if (!parity_q) begin
								parity_d = 1'b1;
								prev_d   = cur;
							end else begin
								parity_d   = 1'b0;
								cmd.status = urbr_pkg::STAT_OK;
								if (prev_q == urbr_pkg::HS_RESET_HI && cur == urbr_pkg::HS_RESET_LO) begin
									done_d  = 1'b0;
									calib_d = 3'd0;
								end
								if (!done_d) begin
									if (prev_q == urbr_pkg::HS_RESET_HI || prev_q == urbr_pkg::HS_PROBE) begin
										cmd.status = urbr_pkg::STAT_READY;
									end else if (prev_q == urbr_pkg::HS_CALIB_HI &&
											cur == urbr_pkg::HS_CALIB_LO) begin
										if (calib_d < urbr_pkg::CALIB_MAX) begin
											calib_d = calib_d + 3'd1;
										end
										cmd.status = (calib_d > urbr_pkg::CALIB_LIMIT) ?
											urbr_pkg::STAT_OK : urbr_pkg::STAT_BUSY;
									end
									if (prev_q == urbr_pkg::HS_DONE_HI && cur == urbr_pkg::HS_DONE_LO) begin
										done_d = 1'b1;
									end
								end
								cmd.push_hs   = 1'b1;
								prev_d        = cur;
								res.irq_pulse = 1'b1;
							end
						end
					end
					urbr_pkg::ADDR_IER: begin
						if (dlab) begin
							dlh_d = item.write_data;
						end else begin
							ier_d = item.write_data;
						end
					end
					urbr_pkg::ADDR_LCR: lcr_d = item.write_data;
					urbr_pkg::ADDR_MCR: mcr_d = item.write_data;
					urbr_pkg::ADDR_SCR: scr_d = item.write_data;
					default: begin
					end
				endcase
			end
			urbr_pkg::OP_TICK: begin
				if (mode_q == urbr_pkg::MODE_HANDSHAKE) begin
					// Queue left intact
				end else if (mode_q != urbr_pkg::MODE_STREAM) begin
					cmd.clear = 1'b1;
				end else if (ier_q[0]) begin
					if (acc_sum >= {1'b0, period_q}) begin
						acc_d           = '0;
						cmd.push_stream = 1'b1;
						res.irq_pulse   = 1'b1;
					end else begin
						acc_d = acc_sum;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= urbr_pkg::MODE_NONE;
			period_q <= urbr_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				urbr_pkg::CFG_RESPONDER_MODE: mode_q   <= cfg_wdata[1:0];
				urbr_pkg::CFG_REFILL_PERIOD:  period_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q    <= '0;
			lcr_q    <= '0;
			mcr_q    <= '0;
			scr_q    <= '0;
			dll_q    <= '0;
			dlh_q    <= '0;
			parity_q <= 1'b0;
			prev_q   <= '0;
			calib_q  <= '0;
			done_q   <= 1'b0;
			acc_q    <= '0;
		end else if (step) begin
			ier_q    <= ier_d;
			lcr_q    <= lcr_d;
			mcr_q    <= mcr_d;
			scr_q    <= scr_d;
			dll_q    <= dll_d;
			dlh_q    <= dlh_d;
			parity_q <= parity_d;
			prev_q   <= prev_d;
			calib_q  <= calib_d;
			done_q   <= done_d;
			acc_q    <= acc_d;
		end
	end

`ifndef SYNTHESIS
	a_calib_sat: assert property (@(posedge clk) disable iff (!arst_n)
		calib_q <= urbr_pkg::CALIB_MAX)
		else $error("calibration count passed its saturation value");

	a_irq_source: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.irq_pulse) |->
		(item.opcode == urbr_pkg::OP_WRITE || item.opcode == urbr_pkg::OP_TICK))
		else $error("interrupt raised by an item that cannot raise one");

	a_hs_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.opcode == urbr_pkg::OP_TICK && mode_q == urbr_pkg::MODE_HANDSHAKE)
		|-> (cmd_g == '0))
		else $error("tick in handshake mode touched the receive queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/uart_regs_with_board_responder.sv =====
// ----------------------------------------------------------------------------
// uart_regs_with_board_responder: 16550-style register subset with responders
// A beat held in the input register has its result captured in the output
// register when it commits. Throughput: one beat per cycle while the output
// is not stalled, set by the single decode-and-update step between the registers.
// Reset: arst_n clears registers, responder state and the receive queue.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_regs_with_board_responder #(
	parameter int unsigned FIFO_DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire urbr_pkg::in_t   in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output urbr_pkg::out_t       out_data,
	input  wire logic            cfg_wr_en,
	input  wire logic [0:0]      cfg_index,
	input  wire logic [15:0]     cfg_wdata
);

	// Stage 1 holds the accepted beat; its result is computed combinationally
	// from the register state and captured in stage 2, the output register.
	logic           valid_s1;
	urbr_pkg::in_t  item_s1;
	logic           valid_s2;
	urbr_pkg::out_t res_s2;
	urbr_pkg::out_t res;
	logic           adv;
	logic           step;

	// Stage 2 can load when it is empty or its beat leaves this cycle. The
	// input side accepts whenever stage 1 is empty or drains at the same edge,
	// so beats stream one per cycle; a result held at the output stops stage 1,
	// and once stage 1 is also full the input stalls.
	assign adv      = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Register, responder and queue state advances only when a beat commits (step),
	// so every beat sees the state left by the one before it; config loads on cfg_wr_en.
	urbr_core #(
		.DEPTH(FIFO_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset; the valid flags qualify them.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

`ifndef SYNTHESIS
	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("committed beat did not reach the output register");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted while both stages were blocked");
`endif

endmodule

`default_nettype wire
